// ===== hw/rtl/awg_pkg.sv =====
// Package for the audio waveform generator: widths, codes, filter
// coefficients, the quarter-wave sine table and controller/datapath structs.
// No dependencies.
package awg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QSINE_BITS      = SINE_TABLE_BITS - 2;
  localparam int QSINE_N         = 1 << QSINE_BITS;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TAP_W      = 24;
  localparam int NUM_TAPS   = 7;
  localparam int FILT_TAPS  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_MODE    = 3'd0,
    REG_PHASE_STEP   = 3'd1,
    REG_VOLUME       = 3'd2,
    REG_SWEEP_RATIO  = 3'd3,
    REG_SWEEP_LENGTH = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_PAUSE = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    WAVE_SINE   = 3'd0,
    WAVE_SQUARE = 3'd1,
    WAVE_TRI    = 3'd2,
    WAVE_SAW    = 3'd3,
    WAVE_WHITE  = 3'd4,
    WAVE_PINK   = 3'd5,
    WAVE_SWEEP  = 3'd6
  } wave_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CMD, OP_SWADV, OP_ROM, OP_SCALE, OP_SWUPD,
    OP_ACCLD, OP_TAPUPD, OP_SUM6, OP_SUMW, OP_TAP6, OP_HILD, OP_PINKFIN, OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_WAVE, MUL_STEP, MUL_POLE, MUL_FEED, MUL_DIRECT, MUL_LAST,
    MUL_HI, MUL_LO
  } mul_sel_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t mul;
    logic [2:0] tap_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] mode;
    logic       run;
    logic       err;
    logic       out_busy;
  } dp_stat_t;

  // Kellet filter coefficients in Q.20.
  localparam logic signed [20:0] POLE_COEF [FILT_TAPS] = '{
    21'sd1047381, 21'sd1041572, 21'sd1016070, 21'sd908591, 21'sd576717, -21'sd798595
  };
  localparam logic signed [20:0] FEED_COEF [FILT_TAPS] = '{
    21'sd58215, 21'sd78723, 21'sd161326, 21'sd325568, 21'sd558841, -21'sd17719
  };
  localparam logic signed [20:0] DIRECT_COEF = 21'sd562246;
  localparam logic signed [20:0] LAST_COEF   = 21'sd121557;

  // Taylor series of sin(k/Q * pi/2), scaled to 32767; elaboration only.
  function automatic logic [15:0] quarter_sine(input int unsigned k);
    longint unsigned one, x, x2, t, r;
    one = 64'd1 << 30;
    x   = (longint'(k) * HALF_PI_Q30) >> QSINE_BITS;
    x2  = (x * x) >> 30;
    t   = one - x2 / 110;
    t   = one - ((x2 * t) >> 30) / 72;
    t   = one - ((x2 * t) >> 30) / 42;
    t   = one - ((x2 * t) >> 30) / 20;
    t   = one - ((x2 * t) >> 30) / 6;
    r   = ((((x * t) >> 30) * 32767) + (one >> 1)) >> 30;
    if (r > 32767) begin
      r = 32767;
    end
    return 16'(r);
  endfunction

  typedef logic [15:0] qsine_tbl_t [QSINE_N];

  function automatic qsine_tbl_t gen_qsine();
    qsine_tbl_t tbl;
    for (int i = 0; i < QSINE_N; i++) begin
      tbl[i] = quarter_sine(i);
    end
    return tbl;
  endfunction

  localparam qsine_tbl_t QSINE     = gen_qsine();
  localparam logic [15:0] QSINE_TOP = quarter_sine(QSINE_N);

endpackage

// ===== hw/rtl/audio_waveform_generator.sv =====
// Top level of the audio waveform generator: joins the controller and the
// datapath. Depends on awg_pkg, awg_ctrl and awg_datapath.
//
// One input transfer carries a command (sample tick, play, pause, stop and
// rewind) and a white noise sample; each input transfer gives exactly one
// output transfer with the audio sample, the playing flag and the
// configuration error flag. Items are handled one at a time by a controller
// that steps a datapath built around a single shared multiplier, so the
// time per item is set by the multiplies the waveform needs: play, pause,
// stop and ticks while stopped are quickest, then square, triangle,
// sawtooth and white noise, then sine, the exponential sweep (one more
// multiply for the step ratio) and pink noise (two multiplies for each of
// six filter taps, two more for the last taps and two for the volume
// scaling of the wide filter sum). A finished result waits in the output
// register; the next item is taken meanwhile and only its final step waits
// for the output to be free. Configuration writes are taken in every cycle
// and must only happen while no item is in flight. Sine comes from a
// quarter-wave table built at elaboration. There is no clearing pass.
module audio_waveform_generator import awg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic signed [15:0]    in_white_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_sample,
  output logic                  out_playing,
  output logic                  out_config_error
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  awg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  awg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_cmd           (in_cmd),
    .in_white_sample  (in_white_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample       (out_sample),
    .out_playing      (out_playing),
    .out_config_error (out_config_error),
    .cmd              (ctl_cmd),
    .stat             (dp_stat)
  );

  // The block never takes a second item right after a transfer in.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on two consecutive cycles");

  // A nonzero sample only comes from a tick while playing.
  a_silent_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_playing |-> out_sample == 16'sd0)
    else $error("nonzero sample while not playing");

endmodule

// ===== hw/rtl/awg_ctrl.sv =====
// Controller of the audio waveform generator: sequences one item through the
// datapath. Depends on awg_pkg.
module awg_ctrl import awg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_EXEC  = 17'h00002,
    S_SWADV = 17'h00004,
    S_ROM   = 17'h00008,
    S_MUL   = 17'h00010,
    S_SCALE = 17'h00020,
    S_SWMUL = 17'h00040,
    S_SWUPD = 17'h00080,
    S_PA    = 17'h00100,
    S_PB    = 17'h00200,
    S_PU    = 17'h00400,
    S_P6    = 17'h00800,
    S_P7    = 17'h01000,
    S_P8    = 17'h02000,
    S_PL    = 17'h04000,
    S_PF    = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] tap_r, tap_nxt;

  always_comb begin
    state_nxt   = state_r;
    tap_nxt     = tap_r;
    cmd.op      = OP_NONE;
    cmd.mul     = MUL_NONE;
    cmd.tap_idx = tap_r;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.op    = OP_CMD;
        tap_nxt   = 3'd0;
        state_nxt = S_DONE;
        if (stat.cmd == CMD_TICK && stat.run && !stat.err) begin
          case (stat.mode) inside
            WAVE_SINE:  state_nxt = S_ROM;
            WAVE_SQUARE, WAVE_TRI, WAVE_SAW, WAVE_WHITE: state_nxt = S_MUL;
            WAVE_PINK:  state_nxt = S_PA;
            WAVE_SWEEP: state_nxt = S_SWADV;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_SWADV: begin
        cmd.op    = OP_SWADV;
        state_nxt = S_ROM;
      end
      S_ROM: begin
        cmd.op    = OP_ROM;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = MUL_WAVE;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = (stat.mode == WAVE_SWEEP) ? S_SWMUL : S_DONE;
      end
      S_SWMUL: begin
        cmd.mul   = MUL_STEP;
        state_nxt = S_SWUPD;
      end
      S_SWUPD: begin
        cmd.op    = OP_SWUPD;
        state_nxt = S_DONE;
      end
      S_PA: begin
        cmd.mul   = MUL_POLE;
        state_nxt = S_PB;
      end
      S_PB: begin
        cmd.op    = OP_ACCLD;
        cmd.mul   = MUL_FEED;
        state_nxt = S_PU;
      end
      S_PU: begin
        cmd.op  = OP_TAPUPD;
        tap_nxt = tap_r + 3'd1;
        state_nxt = (tap_r == 3'(FILT_TAPS - 1)) ? S_P6 : S_PA;
      end
      S_P6: begin
        cmd.op    = OP_SUM6;
        cmd.mul   = MUL_DIRECT;
        state_nxt = S_P7;
      end
      S_P7: begin
        cmd.op    = OP_SUMW;
        cmd.mul   = MUL_LAST;
        state_nxt = S_P8;
      end
      S_P8: begin
        cmd.op    = OP_TAP6;
        cmd.mul   = MUL_HI;
        state_nxt = S_PL;
      end
      S_PL: begin
        cmd.op    = OP_HILD;
        cmd.mul   = MUL_LO;
        state_nxt = S_PF;
      end
      S_PF: begin
        cmd.op    = OP_PINKFIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

endmodule

// ===== hw/rtl/awg_datapath.sv =====
// Datapath of the audio waveform generator: configuration registers, phase
// and sweep state, pink filter taps, one shared multiplier and the output
// register. Depends on awg_pkg.
module awg_datapath import awg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            in_cmd,
  input  logic signed [15:0]    in_white_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_sample,
  output logic                  out_playing,
  output logic                  out_config_error,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat
);

  localparam int PW = PHASE_BITS;
  localparam int QB = QSINE_BITS;

  logic [2:0]  mode_r;
  logic [31:0] step_cfg_r;
  logic [14:0] vol_r;
  logic [31:0] ratio_r;
  logic [23:0] len_r;

  logic [1:0]         cmd_r;
  logic signed [15:0] w_r;

  logic [PW-1:0]             phase_r;
  logic [31:0]               cur_r;
  logic [23:0]               cnt_r;
  logic                      run_r;
  logic signed [TAP_W-1:0]   taps_r [NUM_TAPS];

  logic signed [15:0] sine_r;
  logic signed [65:0] prod_r;
  logic signed [47:0] acc_r;
  logic signed [47:0] sum_r;
  logic [37:0]        hi_r;
  logic signed [15:0] smp_r;

  logic               out_valid_r, out_playing_r, out_err_r;
  logic signed [15:0] out_sample_r;

  logic err;
  assign err = (mode_r == WAVE_SWEEP) && (len_r == 24'd0);

  // Rounds a Q.37 accumulator to Q.17 (ties away from zero), saturates to a tap.
  function automatic logic signed [TAP_W-1:0] round_sat(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [28:0] r;
    mag = v[47] ? 48'(-v) : 48'(v);
    r   = 29'((mag + 48'd524288) >> 20);
    if (!v[47]) begin
      return (r > 29'd8388607) ? 24'sd8388607 : $signed(r[23:0]);
    end
    return (r > 29'd8388608) ? -24'sd8388608 : $signed(24'(-r));
  endfunction

  // Shift that truncates toward zero.
  function automatic logic signed [15:0] trunc_sh(input logic signed [33:0] p,
                                                  input logic by16);
    logic [33:0] mag, q;
    mag = p[33] ? 34'(-p) : 34'(p);
    q   = by16 ? (mag >> 16) : (mag >> 15);
    return p[33] ? $signed(16'(-q)) : $signed(16'(q));
  endfunction

  // Wave shapes from the phase.
  logic [15:0]        top;
  logic [18:0]        tri_x;
  logic signed [18:0] tri_v;
  logic signed [15:0] saw_v;
  logic signed [17:0] w37;

  assign top   = phase_r[PW-1 -: 16];
  assign saw_v = $signed({~top[15], top[14:0]});
  assign tri_x = {1'b0, top, 2'b00};
  assign w37   = $signed({w_r, 2'b00});

  always_comb begin
    if (tri_x <= 19'd65536) begin
      tri_v = $signed(tri_x);
    end else if (tri_x <= 19'd196608) begin
      tri_v = $signed(19'd131072 - tri_x);
    end else begin
      tri_v = $signed(tri_x - 19'd262144);
    end
  end

  // Quarter-wave sine lookup.
  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [1:0]                 quad;
  logic [QB-1:0]              qr, qi;
  logic [15:0]                qmag;
  logic signed [15:0]         sine_v;

  assign sidx = phase_r[PW-1 -: SINE_TABLE_BITS];
  assign quad = sidx[SINE_TABLE_BITS-1 -: 2];
  assign qr   = sidx[QB-1:0];
  assign qi   = quad[0] ? QB'(~qr + 1'b1) : qr;

  always_comb begin
    if (quad[0] && qr == '0) begin
      qmag = QSINE_TOP;
    end else begin
      qmag = QSINE[qi];
    end
    sine_v = quad[1] ? $signed(16'(-qmag)) : $signed(qmag);
  end

  // Shared multiplier.
  logic [47:0]        sum_mag;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  assign sum_mag = sum_r[47] ? 48'(-sum_r) : 48'(sum_r);

  always_comb begin
    mul_a = '0;
    mul_b = $signed({18'd0, vol_r});
    case (cmd.mul)
      MUL_WAVE: begin
        case (mode_r) inside
          WAVE_SINE, WAVE_SWEEP: mul_a = 33'(sine_r);
          WAVE_TRI:              mul_a = 33'(tri_v);
          WAVE_SAW:              mul_a = 33'(saw_v);
          WAVE_WHITE:            mul_a = 33'(w_r);
          default:               mul_a = '0;
        endcase
      end
      MUL_STEP: begin
        mul_a = $signed({1'b0, cur_r});
        mul_b = $signed({1'b0, ratio_r});
      end
      MUL_POLE: begin
        mul_a = 33'(taps_r[cmd.tap_idx]);
        mul_b = 33'(POLE_COEF[cmd.tap_idx]);
      end
      MUL_FEED: begin
        mul_a = 33'(w37);
        mul_b = 33'(FEED_COEF[cmd.tap_idx]);
      end
      MUL_DIRECT: begin
        mul_a = 33'(w37);
        mul_b = 33'(DIRECT_COEF);
      end
      MUL_LAST: begin
        mul_a = 33'(w37);
        mul_b = 33'(LAST_COEF);
      end
      MUL_HI:  mul_a = $signed({10'd0, sum_mag[46:24]});
      MUL_LO:  mul_a = $signed({9'd0, sum_mag[23:0]});
      default: mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Derived values for the update cycles.
  logic signed [TAP_W-1:0] tap_new, tap6_new;
  logic signed [15:0]      scaled;
  logic [31:0]             ns_sat;
  logic [23:0]             cnt_inc;
  logic [62:0]             pink_tot;
  logic [22:0]             pink_q;
  logic signed [15:0]      pink_out;

  assign tap_new  = round_sat(acc_r + prod_r[47:0]);
  assign tap6_new = round_sat(prod_r[47:0]);
  assign ns_sat   = (prod_r[63:62] != 2'd0) ? 32'hFFFF_FFFF : prod_r[61:30];
  assign cnt_inc  = cnt_r + 24'd1;
  assign pink_tot = {1'b0, hi_r, 24'd0} + 63'(prod_r[38:0]);
  assign pink_q   = pink_tot[62:40];

  always_comb begin
    if (mode_r == WAVE_SQUARE) begin
      scaled = top[15] ? $signed({1'b0, vol_r}) : $signed(16'(-{1'b0, vol_r}));
    end else begin
      scaled = trunc_sh(prod_r[33:0], mode_r == WAVE_TRI);
    end
    if (!sum_r[47]) begin
      pink_out = (pink_q > 23'd32767) ? 16'sd32767 : $signed(pink_q[15:0]);
    end else begin
      pink_out = (pink_q > 23'd32768) ? -16'sd32768 : $signed(16'(-pink_q));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 3'd0;
      step_cfg_r  <= 32'd0;
      vol_r       <= 15'd0;
      ratio_r     <= 32'h4000_0000;
      len_r       <= 24'd0;
      phase_r     <= '0;
      cur_r       <= 32'd0;
      cnt_r       <= 24'd0;
      run_r       <= 1'b0;
      taps_r      <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WAVE_MODE:    mode_r     <= cfg_data[2:0];
          REG_PHASE_STEP:   step_cfg_r <= cfg_data;
          REG_VOLUME:       vol_r      <= cfg_data[14:0];
          REG_SWEEP_RATIO:  ratio_r    <= cfg_data;
          REG_SWEEP_LENGTH: len_r      <= cfg_data[23:0];
          default: ;
        endcase
      end

      // A new result takes the output register; otherwise it empties on transfer.
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.mul != MUL_NONE) begin
        prod_r <= mul_p;
      end

      case (cmd.op)
        OP_LOAD: begin
          cmd_r <= in_cmd;
          w_r   <= in_white_sample;
        end
        OP_CMD: begin
          smp_r <= '0;
          sum_r <= '0;
          case (cmd_r)
            CMD_PLAY: begin
              if (!err && !run_r) begin
                run_r <= 1'b1;
                if (cnt_r == 24'd0) begin
                  cur_r <= step_cfg_r;
                end
              end
            end
            CMD_PAUSE: run_r <= 1'b0;
            CMD_STOP: begin
              run_r   <= 1'b0;
              phase_r <= '0;
              cur_r   <= 32'd0;
              cnt_r   <= 24'd0;
              taps_r  <= '{default: '0};
            end
            default: ;
          endcase
        end
        OP_SWADV: phase_r <= phase_r + PW'(cur_r);
        OP_ROM:   sine_r  <= sine_v;
        OP_SCALE: begin
          smp_r <= scaled;
          if (mode_r == WAVE_SINE || mode_r == WAVE_SQUARE ||
              mode_r == WAVE_TRI || mode_r == WAVE_SAW) begin
            phase_r <= phase_r + PW'(step_cfg_r);
          end
        end
        OP_SWUPD: begin
          if (cnt_inc >= len_r) begin
            phase_r <= '0;
            cnt_r   <= 24'd0;
            cur_r   <= step_cfg_r;
          end else begin
            cnt_r <= cnt_inc;
            cur_r <= ns_sat;
          end
        end
        OP_ACCLD: acc_r <= prod_r[47:0];
        OP_TAPUPD: begin
          taps_r[cmd.tap_idx] <= tap_new;
          sum_r <= sum_r + (48'(tap_new) <<< 20);
        end
        OP_SUM6:    sum_r <= sum_r + (48'(taps_r[NUM_TAPS-1]) <<< 20);
        OP_SUMW:    sum_r <= sum_r + prod_r[47:0];
        OP_TAP6:    taps_r[NUM_TAPS-1] <= tap6_new;
        OP_HILD:    hi_r <= prod_r[37:0];
        OP_PINKFIN: smp_r <= pink_out;
        OP_OUT: begin
          out_sample_r  <= smp_r;
          out_playing_r <= run_r;
          out_err_r     <= err;
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_playing      = out_playing_r;
  assign out_config_error = out_err_r;

  assign stat.cmd      = cmd_r;
  assign stat.mode     = mode_r;
  assign stat.run      = run_r;
  assign stat.err      = err;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

// ===== tb/sv/tb_audio_waveform_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for audio_waveform_generator: drives commands and
// noise samples, predicts every result in-line and compares them field by field.
// Depends on awg_pkg and the audio_waveform_generator RTL.
module tb_audio_waveform_generator;
  import awg_pkg::*;

  // Mode code 7 is not a waveform; the block must play silence there.
  localparam logic [2:0] WAVE_SILENT = 3'd7;
  localparam int TBL_N = 1 << SINE_TABLE_BITS;
  localparam int DRAIN_CYCLES = 40;

  // Kellet pink filter coefficients, Q.20.
  localparam longint KEL_POLE [6] = '{1047381, 1041572, 1016070, 908591, 576717, -798595};
  localparam longint KEL_FEED [6] = '{58215, 78723, 161326, 325568, 558841, -17719};
  localparam longint KEL_DIRECT = 562246;
  localparam longint KEL_LAST   = 121557;

  typedef struct {
    logic signed [15:0] sample;
    logic               playing;
    logic               cfg_err;
  } audio_res_t;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] white;
  } audio_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = CMD_TICK;
  logic signed [15:0] in_white_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic out_playing;
  logic out_config_error;

  audio_waveform_generator dut (.*);

  // The clock toggles every half period, for a period of 12 ns.
  always #6 clk = ~clk;

  // Shadow copy of the registers and of the generator state.
  logic [2:0]  m_mode;
  logic [31:0] m_step;
  logic [14:0] m_vol;
  logic [31:0] m_ratio;
  logic [23:0] m_len;
  logic [31:0] m_phase;
  logic [31:0] m_cur_step;
  logic [23:0] m_sweep_cnt;
  longint      m_taps [7];
  logic        m_run;
  int          sine_tbl [TBL_N];

  audio_item_t pending_items[$];
  audio_res_t  expected_audio[$];
  int          fail_count = 0;
  bit          no_gaps = 1'b0;

  // Taylor-series quarter sine, evaluated in the same fixed point as the hardware table.
  function automatic int qwave_amp(input int unsigned k);
    longint unsigned unit, x, x2, t, r;
    unit = 64'd1 << 30;
    x  = (longint'(k) * 64'd1686629713) >> (SINE_TABLE_BITS - 2);
    x2 = (x * x) >> 30;
    t  = unit - x2 / 110;
    t  = unit - ((x2 * t) >> 30) / 72;
    t  = unit - ((x2 * t) >> 30) / 42;
    t  = unit - ((x2 * t) >> 30) / 20;
    t  = unit - ((x2 * t) >> 30) / 6;
    r  = ((((x * t) >> 30) * 32767) + (unit >> 1)) >> 30;
    return (r > 32767) ? 32767 : int'(r);
  endfunction

  function automatic longint trunc_shift(input longint v, input int s);
    return (v < 0) ? -((-v) >> s) : (v >> s);
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    longint half;
    half = longint'(1) << (s - 1);
    return (v < 0) ? -(((-v) + half) >> s) : ((v + half) >> s);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sine_scaled();
    return trunc_shift(longint'(sine_tbl[m_phase[31:32-SINE_TABLE_BITS]]) * m_vol, 15);
  endfunction

  // One pass of the pink filter; updates the taps and returns the scaled sum.
  function automatic longint pink_next(input longint w);
    longint w4, acc, sum;
    w4 = w * 4;
    sum = 0;
    for (int i = 0; i < 6; i++) begin
      acc = m_taps[i] * KEL_POLE[i] + w4 * KEL_FEED[i];
      m_taps[i] = clamp(round_shift(acc, 20), -8388608, 8388607);
      sum += m_taps[i] * 1048576;
    end
    sum += m_taps[6] * 1048576 + w4 * KEL_DIRECT;
    m_taps[6] = clamp(round_shift(w4 * KEL_LAST, 20), -8388608, 8388607);
    return clamp(trunc_shift(sum * m_vol, 40), -32768, 32767);
  endfunction

  function automatic void rewind_gen();
    m_phase = '0;
    m_cur_step = '0;
    m_sweep_cnt = '0;
    for (int i = 0; i < 7; i++) begin
      m_taps[i] = 0;
    end
  endfunction

  // Works out the result of one accepted item and queues it.
  function automatic void predict_audio(input logic [1:0] c, input logic signed [15:0] w);
    audio_res_t r;
    logic err;
    longint s, x, tri_val;
    longint unsigned ns;
    logic [15:0] top;
    err = (m_mode == WAVE_SWEEP) && (m_len == 0);
    s = 0;
    top = m_phase[31:16];
    case (c)
      CMD_PLAY: begin
        if (!err && !m_run) begin
          m_run = 1'b1;
          if (m_sweep_cnt == 0) m_cur_step = m_step;
        end
      end
      CMD_PAUSE: m_run = 1'b0;
      CMD_STOP: begin
        m_run = 1'b0;
        rewind_gen();
      end
      default: begin
        if (m_run && !err) begin
          case (m_mode)
            WAVE_SINE: begin
              s = sine_scaled();
              m_phase += m_step;
            end
            WAVE_SQUARE: begin
              s = top[15] ? longint'(m_vol) : -longint'(m_vol);
              m_phase += m_step;
            end
            WAVE_TRI: begin
              x = longint'(top) * 4;
              if (x <= 65536) tri_val = x;
              else if (x <= 196608) tri_val = 131072 - x;
              else tri_val = x - 262144;
              s = trunc_shift(tri_val * m_vol, 16);
              m_phase += m_step;
            end
            WAVE_SAW: begin
              s = trunc_shift((longint'(top) - 32768) * m_vol, 15);
              m_phase += m_step;
            end
            WAVE_WHITE: s = trunc_shift(longint'(w) * m_vol, 15);
            WAVE_PINK:  s = pink_next(longint'(w));
            WAVE_SWEEP: begin
              m_phase += m_cur_step;
              s = sine_scaled();
              ns = (longint'(m_cur_step) * longint'(m_ratio)) >> 30;
              m_cur_step = (ns > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ns[31:0];
              m_sweep_cnt = m_sweep_cnt + 24'd1;
              if (m_sweep_cnt >= m_len) begin
                m_phase = '0;
                m_sweep_cnt = '0;
                m_cur_step = m_step;
              end
            end
            default: s = 0;
          endcase
        end
      end
    endcase
    r.sample = s[15:0];
    r.playing = m_run;
    r.cfg_err = err;
    expected_audio.insert(expected_audio.size(), r);
  endfunction

  // Input driver: predicts each transfer as it happens, then offers the next
  // queued item after a random gap. in_valid gets a single assignment per edge.
  int in_gap = 0;
  always @(posedge clk) begin
    logic nv;
    audio_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        predict_audio(in_cmd, in_white_sample);
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_cmd <= it.cmd;
          in_white_sample <= it.white;
          nv = 1'b1;
          in_gap = no_gaps ? 0 : $urandom_range(0, 5);
        end
      end
      in_valid <= nv;
    end
  end

  // Output monitor: checks each transfer against the oldest expectation; after
  // each one it stalls out_ready for a random number of cycles unless no_gaps is set.
  int out_stall = 0;
  always @(posedge clk) begin
    audio_res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_audio.size() == 0) begin
          $error("unexpected result: sample %0d playing %0b config_error %0b",
                 out_sample, out_playing, out_config_error);
          fail_count++;
        end else begin
          e = expected_audio.pop_front();
          if (out_sample !== e.sample) begin
            $error("sample: expected %0d, actual %0d", e.sample, out_sample);
            fail_count++;
          end
          if (out_playing !== e.playing) begin
            $error("playing: expected %0b, actual %0b", e.playing, out_playing);
            fail_count++;
          end
          if (out_config_error !== e.cfg_err) begin
            $error("config_error: expected %0b, actual %0b", e.cfg_err, out_config_error);
            fail_count++;
          end
        end
        out_stall = no_gaps ? 0 : $urandom_range(0, 5);
      end
      out_ready <= (out_stall == 0);
      if (out_stall > 0) out_stall--;
    end
  end

  // Waits until the sender has nothing left and every result has come back,
  // then lets the block settle before a register write. The check is made on
  // the falling edge, when the driver's updates of the rising edge have landed.
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_audio.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WAVE_MODE:    m_mode = val[2:0];
      REG_PHASE_STEP:   m_step = val;
      REG_VOLUME:       m_vol = val[14:0];
      REG_SWEEP_RATIO:  m_ratio = val;
      REG_SWEEP_LENGTH: m_len = val[23:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(input logic [2:0] mode, input logic [31:0] step,
                         input logic [14:0] vol, input logic [31:0] ratio,
                         input logic [23:0] len);
    wait_idle();
    write_reg(REG_WAVE_MODE, 32'(mode));
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_VOLUME, 32'(vol));
    write_reg(REG_SWEEP_RATIO, ratio);
    write_reg(REG_SWEEP_LENGTH, 32'(len));
  endtask

  task automatic add(input cmd_t c, input logic signed [15:0] w);
    audio_item_t it;
    it.cmd = c;
    it.white = w;
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic cmd_t rand_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return CMD_PAUSE;
    if (r < 10) return CMD_STOP;
    if (r < 18) return CMD_PLAY;
    return CMD_TICK;
  endfunction

  // Stimulus: a directed part, then random phases each with its own settings.
  initial begin
    logic [2:0] mode;
    logic [31:0] step, ratio;
    logic [14:0] vol;
    logic [23:0] len;
    int n;
    for (int i = 0; i < TBL_N; i++) begin
      n = i % (TBL_N / 4);
      n = qwave_amp(((i / (TBL_N / 4)) & 1) ? (TBL_N / 4) - n : n);
      sine_tbl[i] = ((i / (TBL_N / 2)) & 1) ? -n : n;
    end
    m_mode = WAVE_SINE;
    m_step = '0;
    m_vol = '0;
    m_ratio = 32'h4000_0000;
    m_len = '0;
    m_run = 1'b0;
    rewind_gen();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sine at full volume: tick while stopped, play, pause, resume, stop.
    set_all(WAVE_SINE, 32'h1000_0000, 15'h7FFF, 32'h4000_0000, 24'd0);
    add(CMD_TICK, 16'sd0);
    add(CMD_PLAY, 16'sd0);
    repeat (3) add(CMD_TICK, 16'sd0);
    add(CMD_PAUSE, 16'sd0);
    add(CMD_TICK, 16'sd0);
    add(CMD_PLAY, 16'sd0);
    add(CMD_TICK, 16'sd0);
    add(CMD_STOP, 16'sd0);
    add(CMD_TICK, 16'sd0);

    // Sweep with zero length raises the error flag and refuses to play.
    set_all(WAVE_SWEEP, 32'hFFFF_FFFF, 15'h7FFF, 32'hFFFF_FFFF, 24'd0);
    add(CMD_PLAY, 16'sd0);
    add(CMD_TICK, 16'sd0);
    // A short sweep with the largest ratio saturates the step and restarts.
    set_all(WAVE_SWEEP, 32'hFFFF_FFFF, 15'h7FFF, 32'hFFFF_FFFF, 24'd3);
    add(CMD_PLAY, 16'sd0);
    repeat (2) add(CMD_TICK, 16'sd0);
    add(CMD_PAUSE, 16'sd0);
    add(CMD_PLAY, 16'sd0);
    repeat (3) add(CMD_TICK, 16'sd0);

    // Noise at the extremes of the input sample, then the silent mode code.
    set_all(WAVE_PINK, 32'h8000_0000, 15'h7FFF, 32'h0, 24'hFF_FFFF);
    add(CMD_PLAY, 16'sd0);
    for (int i = 0; i < 4; i++) add(CMD_TICK, (i & 1) ? -16'sd32768 : 16'sd32767);
    set_all(WAVE_WHITE, 32'h8000_0000, 15'h7FFF, 32'h0, 24'd1);
    add(CMD_TICK, -16'sd32768);
    add(CMD_TICK, 16'sd32767);
    set_all(WAVE_SILENT, 32'h8000_0000, 15'h7FFF, 32'h0, 24'd1);
    add(CMD_TICK, 16'sd1);

    // Random phases; every phase plays, then mostly ticks with random commands mixed in.
    for (int ph = 0; ph < 24; ph++) begin
      mode = ($urandom_range(0, 15) == 0) ? WAVE_SILENT : 3'($urandom_range(0, 6));
      case ($urandom_range(0, 5))
        0: step = 32'h0;
        1: step = 32'hFFFF_FFFF;
        2: step = 32'h8000_0000;
        default: step = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: vol = 15'h0;
        1: vol = 15'h7FFF;
        default: vol = 15'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: ratio = 32'h0;
        1: ratio = 32'hFFFF_FFFF;
        2: ratio = $urandom;
        default: ratio = 32'h4000_0000 + $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      endcase
      case ($urandom_range(0, 7))
        0: len = 24'd0;
        1: len = 24'hFF_FFFF;
        default: len = 24'($urandom_range(1, 40));
      endcase
      no_gaps = (ph % 5 == 2);
      set_all(mode, step, vol, ratio, len);
      add(CMD_PLAY, 16'($urandom));
      for (int i = 0; i < 66; i++) begin
        // Midway through one phase the sender holds back until every result is in.
        if (ph == 7 && i == 33) begin
          while (pending_items.size() > 0 || in_valid || expected_audio.size() > 0) begin
            @(negedge clk);
          end
        end
        add(rand_cmd(), 16'($urandom));
      end
    end

    wait_idle();
    if (fail_count == 0 && expected_audio.size() == 0) begin
      $display("tb_audio_waveform_generator OK");
    end else begin
      $display("tb_audio_waveform_generator NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("tb_audio_waveform_generator NOT OK");
    $finish;
  end

endmodule
